// ===== rtl/t8cpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// t8cpu_pkg
// Types and instruction codes shared by the tiny 8-bit processor core.
// ----------------------------------------------------------------------------
package t8cpu_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned ADDR_W = 8;
  localparam int unsigned MEM_DEPTH = 1 << ADDR_W;

  localparam logic [DATA_W-1:0] SP_RESET = 8'hFF;
  localparam logic [2:0]        SHIFT_MASK = 3'h7;

  // Opcodes, taken from the high nibble of an instruction.
  localparam logic [3:0] OP_UNARY = 4'h0;
  localparam logic [3:0] OP_MOV   = 4'h1;
  localparam logic [3:0] OP_ADD   = 4'h2;
  localparam logic [3:0] OP_SUB   = 4'h3;
  localparam logic [3:0] OP_MUL   = 4'h4;
  localparam logic [3:0] OP_SHL   = 4'h5;
  localparam logic [3:0] OP_SHR   = 4'h6;
  localparam logic [3:0] OP_AND   = 4'h7;
  localparam logic [3:0] OP_OR    = 4'h8;
  localparam logic [3:0] OP_XOR   = 4'h9;
  localparam logic [3:0] OP_LOAD  = 4'hA;
  localparam logic [3:0] OP_STORE = 4'hB;
  localparam logic [3:0] OP_IMM   = 4'hC;
  localparam logic [3:0] OP_BLEZ  = 4'hD;
  localparam logic [3:0] OP_STACK = 4'hE;
  localparam logic [3:0] OP_HALT  = 4'hF;

  // Sub-operations carried in the register B field.
  localparam logic [1:0] UN_NEG = 2'd0;
  localparam logic [1:0] UN_INV = 2'd1;
  localparam logic [1:0] UN_NOT = 2'd2;
  localparam logic [1:0] UN_PC  = 2'd3;

  localparam logic [1:0] IMM_MOV = 2'd0;
  localparam logic [1:0] IMM_ADD = 2'd1;
  localparam logic [1:0] IMM_AND = 2'd2;
  localparam logic [1:0] IMM_LD  = 2'd3;

  localparam logic [1:0] STK_PUSH = 2'd0;
  localparam logic [1:0] STK_POP  = 2'd1;
  localparam logic [1:0] STK_CALL = 2'd2;
  localparam logic [1:0] STK_RET  = 2'd3;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EXEC = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_OP2,
    S_OP3
  } state_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] load_address;
    logic [DATA_W-1:0] load_data;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] program_counter;
    logic [DATA_W-1:0] reg0;
    logic [DATA_W-1:0] reg1;
    logic [DATA_W-1:0] reg2;
    logic [DATA_W-1:0] reg3;
    logic [ADDR_W-1:0] stack_pointer;
    logic              halted;
    logic              store_valid;
    logic [ADDR_W-1:0] store_address;
    logic [DATA_W-1:0] store_data;
  } out_item_t;

endpackage

// ===== rtl/tiny_8bit_cpu_core_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_core_unit
// Small 8-bit processor around a 256-byte memory with one registered read.
// ----------------------------------------------------------------------------
// Each transaction either writes one program byte or executes the instruction
// at the program counter, and returns one result with the architectural state
// and any memory write. A load, or an execute while halted, finishes in S_IDLE.
// Register instructions, store, branch, push and halt also pass S_INS (fetch,
// then execute). Memory load, immediate forms, pop, call and return add S_OP2,
// and the indirect immediate load adds S_OP3. These steps are set by the single
// registered memory read port: every dependent memory read costs a state. The
// memory reads as zero after reset through one valid flag per byte, so no
// clearing pass is needed and the block is ready right out of reset. A new
// transaction is taken while the previous result still waits, as long as the
// result register frees up at the same edge.
module tiny_8bit_cpu_core_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  t8cpu_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output t8cpu_pkg::out_item_t out_data
);
  import t8cpu_pkg::*;

  state_t state_r, state_nxt;

  logic [DATA_W-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_r;
  logic [DATA_W-1:0] rdata_r;
  logic rvld_r;
  logic [DATA_W-1:0] rd;

  logic [DATA_W-1:0] rf_r [4];
  logic [DATA_W-1:0] rf_nxt [4];
  logic [ADDR_W-1:0] pc_r, pc_nxt;
  logic [ADDR_W-1:0] sp_r, sp_nxt;
  logic              halt_r, halt_nxt;
  logic [DATA_W-1:0] ins_r, ins_nxt;

  out_item_t out_r;
  logic      out_valid_r;

  logic              in_fire;
  logic              fin;
  logic              need_op2;
  logic              need_op3;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [DATA_W-1:0] mem_wd;
  logic [ADDR_W-1:0] raddr;
  logic              st_v;

  logic [DATA_W-1:0] cur_ins;
  logic [3:0]        op;
  logic [1:0]        ra, rb;
  logic [DATA_W-1:0] a, b;
  logic [2*DATA_W-1:0] prod;
  logic [ADDR_W-1:0] pc1, pc2, spm, spp;

  assign in_fire = in_valid && in_ready;
  assign rd      = rvld_r ? rdata_r : '0;

  assign cur_ins = (state_r == S_INS) ? rd : ins_r;
  assign op      = cur_ins[7:4];
  assign ra      = cur_ins[3:2];
  assign rb      = cur_ins[1:0];
  assign a       = rf_r[ra];
  assign b       = rf_r[rb];
  assign prod    = a * b;
  assign pc1     = pc_r + 8'd1;
  assign pc2     = pc_r + 8'd2;
  assign spm     = sp_r - 8'd1;
  assign spp     = sp_r + 8'd1;

  // Memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[raddr];
    rvld_r  <= vld_r[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (mem_we) begin
      vld_r[mem_wa] <= 1'b1;
    end
  end

  // Datapath: next architectural state and memory accesses per step.
  always_comb begin
    pc_nxt   = pc_r;
    rf_nxt   = rf_r;
    sp_nxt   = sp_r;
    halt_nxt = halt_r;
    ins_nxt  = ins_r;
    mem_we   = 1'b0;
    mem_wa   = '0;
    mem_wd   = '0;
    st_v     = 1'b0;
    raddr    = pc_r;
    fin      = 1'b0;
    need_op2 = 1'b0;
    need_op3 = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.action == ACT_LOAD) begin
            mem_we = 1'b1;
            mem_wa = in_data.load_address;
            mem_wd = in_data.load_data;
            fin    = 1'b1;
          end else if (halt_r) begin
            fin = 1'b1;
          end
        end
      end
      S_INS: begin
        ins_nxt = rd;
        pc_nxt  = pc1;
        unique case (op)
          OP_UNARY: begin
            fin = 1'b1;
            case (rb)
              UN_NEG:  rf_nxt[ra] = 8'd0 - a;
              UN_INV:  rf_nxt[ra] = ~a;
              UN_NOT:  rf_nxt[ra] = (a == 8'd0) ? 8'd1 : 8'd0;
              default: rf_nxt[ra] = pc_r;
            endcase
          end
          OP_MOV: begin fin = 1'b1; rf_nxt[ra] = b; end
          OP_ADD: begin fin = 1'b1; rf_nxt[ra] = a + b; end
          OP_SUB: begin fin = 1'b1; rf_nxt[ra] = a - b; end
          OP_MUL: begin fin = 1'b1; rf_nxt[ra] = prod[DATA_W-1:0]; end
          OP_SHL: begin fin = 1'b1; rf_nxt[ra] = a << (b[2:0] & SHIFT_MASK); end
          OP_SHR: begin fin = 1'b1; rf_nxt[ra] = a >> (b[2:0] & SHIFT_MASK); end
          OP_AND: begin fin = 1'b1; rf_nxt[ra] = a & b; end
          OP_OR:  begin fin = 1'b1; rf_nxt[ra] = a | b; end
          OP_XOR: begin fin = 1'b1; rf_nxt[ra] = a ^ b; end
          OP_LOAD: begin
            need_op2 = 1'b1;
            raddr    = b;
          end
          OP_STORE: begin
            fin    = 1'b1;
            mem_we = 1'b1;
            mem_wa = b;
            mem_wd = a;
            st_v   = 1'b1;
          end
          OP_IMM: begin
            need_op2 = 1'b1;
            raddr    = pc1;
          end
          OP_BLEZ: begin
            fin = 1'b1;
            if (a == 8'd0 || a[7]) begin
              pc_nxt = b;
            end
          end
          OP_STACK: begin
            case (rb)
              STK_PUSH: begin
                fin    = 1'b1;
                sp_nxt = spm;
                mem_we = 1'b1;
                mem_wa = spm;
                mem_wd = a;
                st_v   = 1'b1;
              end
              STK_CALL: begin
                need_op2 = 1'b1;
                raddr    = pc1;
              end
              default: begin
                need_op2 = 1'b1;
                raddr    = sp_r;
              end
            endcase
          end
          default: begin
            fin      = 1'b1;
            halt_nxt = 1'b1;
            pc_nxt   = pc_r;
          end
        endcase
        // Multi-step instructions keep the pc of the instruction until their last
        // step, which computes the next pc from it, or from memory for call and return.
        if (need_op2) begin
          pc_nxt = pc_r;
        end
      end
      S_OP2: begin
        unique case (op)
          OP_LOAD: begin
            fin        = 1'b1;
            rf_nxt[ra] = rd;
            pc_nxt     = pc1;
          end
          OP_IMM: begin
            pc_nxt = pc2;
            case (rb)
              IMM_MOV: begin fin = 1'b1; rf_nxt[ra] = rd; end
              IMM_ADD: begin fin = 1'b1; rf_nxt[ra] = a + rd; end
              IMM_AND: begin fin = 1'b1; rf_nxt[ra] = a & rd; end
              default: begin
                need_op3 = 1'b1;
                pc_nxt   = pc_r;
                raddr    = rd;
              end
            endcase
          end
          default: begin
            fin = 1'b1;
            case (rb)
              STK_POP: begin
                rf_nxt[ra] = rd;
                sp_nxt     = spp;
                pc_nxt     = pc1;
              end
              STK_CALL: begin
                sp_nxt = spm;
                mem_we = 1'b1;
                mem_wa = spm;
                mem_wd = pc2;
                st_v   = 1'b1;
                // The target counts as read after the return address is pushed, so a
                // push onto the target byte forwards the return address.
                pc_nxt = (spm == pc1) ? pc2 : rd;
              end
              default: begin
                sp_nxt = spp;
                pc_nxt = rd;
              end
            endcase
          end
        endcase
      end
      S_OP3: begin
        fin        = 1'b1;
        rf_nxt[ra] = rd;
        pc_nxt     = pc2;
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.action == ACT_EXEC && !halt_r) begin
          state_nxt = S_INS;
        end
      end
      S_INS:   state_nxt = need_op2 ? S_OP2 : S_IDLE;
      S_OP2:   state_nxt = need_op3 ? S_OP3 : S_IDLE;
      S_OP3:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = (state_r == S_IDLE) && (!out_valid_r || out_ready);
    out_valid = out_valid_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      sp_r        <= SP_RESET;
      halt_r      <= 1'b0;
      rf_r        <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      sp_r    <= sp_nxt;
      halt_r  <= halt_nxt;
      rf_r    <= rf_nxt;
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ins_r <= ins_nxt;
    if (fin) begin
      out_r.program_counter <= pc_nxt;
      out_r.reg0            <= rf_nxt[0];
      out_r.reg1            <= rf_nxt[1];
      out_r.reg2            <= rf_nxt[2];
      out_r.reg3            <= rf_nxt[3];
      out_r.stack_pointer   <= sp_nxt;
      out_r.halted          <= halt_nxt;
      out_r.store_valid     <= st_v;
      out_r.store_address   <= st_v ? mem_wa : '0;
      out_r.store_data      <= st_v ? mem_wd : '0;
    end
  end

endmodule

// ===== tb/sv/tiny_8bit_cpu_core_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_core_unit_test
// Self-checking testbench for the tiny 8-bit processor core.
// ----------------------------------------------------------------------------
// The bench drives memory loads and execute requests into the core and keeps
// its own copy of the processor state to predict every result. The sequence
// covers a hand-written call, return and wrap scenario, a sweep over every
// opcode but halt and every sub-operation, random short programs mixed with
// random noise, a long result stall that backs up the core, and finally halt.
// Results are checked field by field, in order, under random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_core_unit_test;
  import t8cpu_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam int ITEM_TARGET  = 1250;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  tiny_8bit_cpu_core_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #CLK_HALF clk = ~clk;

  // Shadow copy of the processor state.
  logic [7:0] mem_shadow [256];
  logic [7:0] regs_shadow [4];
  logic [7:0] pc_shadow = 8'h00;
  logic [7:0] sp_shadow = SP_RESET;
  logic       halt_shadow = 1'b0;
  bit         opcode_hit [16];

  out_item_t expected_results [$];

  int errors        = 0;
  int items_sent    = 0;
  int loads_sent    = 0;
  int execs_sent    = 0;
  int results_seen  = 0;
  int stores_seen   = 0;
  int burst_left    = 0;
  int idle_cycles   = 0;
  bit hold_request  = 1'b0;
  int holds_done    = 0;

  initial begin
    for (int i = 0; i < 256; i++) mem_shadow[i] = 8'h00;
    for (int i = 0; i < 4; i++) regs_shadow[i] = 8'h00;
  end

  // Applies one transaction to the shadow state and returns the result.
  task automatic cpu_execute(input in_item_t it, output out_item_t res);
    logic [7:0] ins, a, b, imm, pc_plus1, nxt, ret_addr;
    logic [3:0] op;
    logic [1:0] ra, rb;
    res = '0;
    if (it.action == ACT_LOAD) begin
      mem_shadow[it.load_address] = it.load_data;
    end else if (!halt_shadow) begin
      ins      = mem_shadow[pc_shadow];
      op       = ins[7:4];
      ra       = ins[3:2];
      rb       = ins[1:0];
      a        = regs_shadow[ra];
      b        = regs_shadow[rb];
      pc_plus1 = pc_shadow + 8'd1;
      nxt      = pc_plus1;
      imm      = mem_shadow[pc_plus1];
      opcode_hit[op] = 1'b1;
      case (op)
        OP_UNARY: begin
          case (rb)
            UN_NEG: regs_shadow[ra] = 8'd0 - a;
            UN_INV: regs_shadow[ra] = ~a;
            UN_NOT: regs_shadow[ra] = (a == 8'd0) ? 8'd1 : 8'd0;
            default: regs_shadow[ra] = pc_shadow;
          endcase
        end
        OP_MOV: regs_shadow[ra] = b;
        OP_ADD: regs_shadow[ra] = a + b;
        OP_SUB: regs_shadow[ra] = a - b;
        OP_MUL: regs_shadow[ra] = a * b;
        OP_SHL: regs_shadow[ra] = a << (b[2:0] & SHIFT_MASK);
        OP_SHR: regs_shadow[ra] = a >> (b[2:0] & SHIFT_MASK);
        OP_AND: regs_shadow[ra] = a & b;
        OP_OR:  regs_shadow[ra] = a | b;
        OP_XOR: regs_shadow[ra] = a ^ b;
        OP_LOAD: regs_shadow[ra] = mem_shadow[b];
        OP_STORE: begin
          mem_shadow[b]     = a;
          res.store_valid   = 1'b1;
          res.store_address = b;
          res.store_data    = a;
        end
        OP_IMM: begin
          case (rb)
            IMM_MOV: regs_shadow[ra] = imm;
            IMM_ADD: regs_shadow[ra] = a + imm;
            IMM_AND: regs_shadow[ra] = a & imm;
            default: regs_shadow[ra] = mem_shadow[imm];
          endcase
          nxt = pc_shadow + 8'd2;
        end
        OP_BLEZ: begin
          if (a == 8'd0 || a[7]) nxt = b;
        end
        OP_STACK: begin
          case (rb)
            STK_PUSH: begin
              sp_shadow             = sp_shadow - 8'd1;
              mem_shadow[sp_shadow] = a;
              res.store_valid       = 1'b1;
              res.store_address     = sp_shadow;
              res.store_data        = a;
            end
            STK_POP: begin
              regs_shadow[ra] = mem_shadow[sp_shadow];
              sp_shadow       = sp_shadow + 8'd1;
            end
            STK_CALL: begin
              ret_addr              = pc_shadow + 8'd2;
              sp_shadow             = sp_shadow - 8'd1;
              mem_shadow[sp_shadow] = ret_addr;
              res.store_valid       = 1'b1;
              res.store_address     = sp_shadow;
              res.store_data        = ret_addr;
              // The target is read after the return address is written.
              nxt = mem_shadow[pc_plus1];
            end
            default: begin
              nxt       = mem_shadow[sp_shadow];
              sp_shadow = sp_shadow + 8'd1;
            end
          endcase
        end
        default: begin
          halt_shadow = 1'b1;
          nxt         = pc_shadow;
        end
      endcase
      pc_shadow = nxt;
    end
    res.program_counter = pc_shadow;
    res.reg0            = regs_shadow[0];
    res.reg1            = regs_shadow[1];
    res.reg2            = regs_shadow[2];
    res.reg3            = regs_shadow[3];
    res.stack_pointer   = sp_shadow;
    res.halted          = halt_shadow;
  endtask

  // Offers one transaction in bursts with random gaps and records the
  // prediction once the core takes it.
  task automatic send_item(input in_item_t it);
    int gap;
    out_item_t res;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cpu_execute(it, res);
    expected_results.push_back(res);
    items_sent++;
    if (it.action == ACT_LOAD) loads_sent++;
    else execs_sent++;
  endtask

  task automatic load_byte(input logic [7:0] addr, input logic [7:0] data);
    in_item_t it;
    it.action       = ACT_LOAD;
    it.load_address = addr;
    it.load_data    = data;
    send_item(it);
  endtask

  // The load fields are don't-care on an execute, so they carry noise.
  task automatic exec_raw();
    in_item_t it;
    it.action       = ACT_EXEC;
    it.load_address = 8'($urandom);
    it.load_data    = 8'($urandom);
    send_item(it);
  endtask

  // Halt is permanent, so a halt byte at the pc is replaced before executing.
  task automatic exec_safe();
    if (mem_shadow[pc_shadow][7:4] == OP_HALT)
      load_byte(pc_shadow, {4'($urandom_range(0, 14)), 4'($urandom)});
    exec_raw();
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] corner [5];
    corner = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 1) == 0) return corner[$urandom_range(0, 4)];
    return 8'($urandom);
  endfunction

  task automatic wait_all_results();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Call through a pc of 255, return address wrap, and a taken branch.
  task automatic test_wrap_call_return();
    exec_raw();
    load_byte(8'h01, {OP_IMM, 2'd0, IMM_MOV});
    load_byte(8'h02, 8'h80);
    load_byte(8'h03, {OP_IMM, 2'd1, IMM_MOV});
    load_byte(8'h04, 8'hFF);
    load_byte(8'h05, {OP_BLEZ, 2'd0, 2'd1});
    load_byte(8'hFF, {OP_STACK, 2'd0, STK_CALL});
    load_byte(8'h00, 8'h10);
    load_byte(8'h10, {OP_STACK, 2'd0, STK_RET});
    load_byte(8'h20, 8'h00);
    repeat (6) exec_raw();
  endtask

  task automatic test_opcode_sweep();
    logic [3:0] op4;
    logic [1:0] rb;
    bit has_sub;
    for (int op = 0; op < 15; op++) begin
      op4     = op[3:0];
      has_sub = (op4 == OP_UNARY) || (op4 == OP_IMM) || (op4 == OP_STACK);
      for (int sub = 0; sub < 4; sub++) begin
        if (has_sub || sub == 0) begin
          rb = has_sub ? sub[1:0] : 2'($urandom);
          load_byte(pc_shadow, {op4, 2'($urandom), rb});
          if (op4 == OP_IMM || (op4 == OP_STACK && rb == STK_CALL))
            load_byte(pc_shadow + 8'd1, pick_operand());
          exec_raw();
        end
      end
    end
  endtask

  // A short well-formed program written at the pc and then run.
  task automatic random_program();
    int n;
    logic [7:0] addr;
    logic [3:0] op4;
    logic [1:0] rb;
    n    = $urandom_range(2, 8);
    addr = pc_shadow;
    for (int i = 0; i < n; i++) begin
      op4 = 4'($urandom_range(0, 14));
      rb  = 2'($urandom);
      load_byte(addr, {op4, 2'($urandom), rb});
      addr++;
      if (op4 == OP_IMM || (op4 == OP_STACK && rb == STK_CALL)) begin
        load_byte(addr, pick_operand());
        addr++;
      end
    end
    repeat (n) exec_safe();
  endtask

  task automatic random_noise();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0) load_byte(8'($urandom), 8'($urandom));
      else exec_safe();
    end
  endtask

  task automatic test_random_programs(input int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) random_program();
      else random_noise();
    end
  endtask

  // The receiver holds off while the sender keeps offering transactions.
  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (6) random_program();
  endtask

  task automatic test_halt();
    load_byte(pc_shadow, {OP_HALT, 4'($urandom)});
    exec_raw();
    exec_raw();
    load_byte(8'($urandom), 8'($urandom));
    repeat (8) begin
      if ($urandom_range(0, 1) == 0) load_byte(8'($urandom), 8'($urandom));
      else exec_raw();
    end
  endtask

  // Receiver: stretches of full speed alternate with random stall densities.
  initial begin : rx_stall
    int stretch;
    int ready_pct;
    stretch   = 0;
    ready_pct = 100;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        holds_done++;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end
        stretch--;
        out_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, out_data);
      end else begin
        exp_r = expected_results.pop_front();
        if (exp_r.store_valid) stores_seen++;
        check_field("program_counter", exp_r.program_counter, out_data.program_counter);
        check_field("reg0", exp_r.reg0, out_data.reg0);
        check_field("reg1", exp_r.reg1, out_data.reg1);
        check_field("reg2", exp_r.reg2, out_data.reg2);
        check_field("reg3", exp_r.reg3, out_data.reg3);
        check_field("stack_pointer", exp_r.stack_pointer, out_data.stack_pointer);
        check_field("halted", 8'(exp_r.halted), 8'(out_data.halted));
        check_field("store_valid", 8'(exp_r.store_valid), 8'(out_data.store_valid));
        check_field("store_address", exp_r.store_address, out_data.store_address);
        check_field("store_data", exp_r.store_data, out_data.store_data);
      end
    end
  end

  // Watchdog on cycles in which neither channel completes a transaction.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, expected_results.size());
      $display("FAIL tiny_8bit_cpu_core_unit");
      $finish;
    end
  end

  initial begin : main_seq
    int ops_covered;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_wrap_call_return();
    wait_all_results();
    test_opcode_sweep();
    wait_all_results();
    test_random_programs(ITEM_TARGET / 2);
    wait_all_results();
    test_backpressure();
    wait_all_results();
    test_random_programs(ITEM_TARGET - 12);
    test_halt();
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end

    ops_covered = 0;
    for (int i = 0; i < 16; i++) if (opcode_hit[i]) ops_covered++;
    $display("Run covered %0d transactions (%0d loads, %0d executes), %0d results checked.",
             items_sent, loads_sent, execs_sent, results_seen);
    $display("Opcodes executed: %0d of 16, memory writes: %0d, long stalls: %0d, halted: %0d.",
             ops_covered, stores_seen, holds_done, halt_shadow);

    if (errors == 0) begin
      $display("PASS tiny_8bit_cpu_core_unit");
    end else begin
      $display("FAIL tiny_8bit_cpu_core_unit");
    end
    $finish;
  end

endmodule
